/* design/sdfd_pkg.sv */
`default_nettype none

package sdfd_pkg;

   localparam int TEXT_LEN_DEF = 20;
   localparam int FAST_MAX_DEF = 28;

   localparam logic [1:0] CMD_DATA  = 2'd0;
   localparam logic [1:0] CMD_SYNC  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] KIND_POS  = 2'd0;
   localparam logic [1:0] KIND_FAST = 2'd1;
   localparam logic [1:0] KIND_TEXT = 2'd2;

   localparam logic [3:0] TYPE_POS        = 4'h3;
   localparam logic [3:0] TYPE_TEXT       = 4'h4;
   localparam logic [3:0] TYPE_FAST_SHORT = 4'h8;
   localparam logic [3:0] TYPE_FAST_LONG  = 4'h9;

   localparam logic [4:0] LONG_EXTRA = 5'd16;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } sdfd_state_type;

   typedef struct packed {
      logic load;
      logic emit;
   } sdfd_ctl_type;

   typedef struct packed {
      logic job_some;
      logic job_last;
      logic out_free;
   } sdfd_stat_type;

endpackage

`default_nettype wire

/* design/sdfd_req_if.sv */
`default_nettype none

interface sdfd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] voice_first;
   logic [31:0] voice_second;
   logic [23:0] slow_data;

   modport source (output valid, command, voice_first, voice_second, slow_data,
                   input ready);
   modport sink (input valid, command, voice_first, voice_second, slow_data,
                 output ready);
endinterface

`default_nettype wire

/* design/sdfd_rsp_if.sv */
`default_nettype none

interface sdfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] out_byte;
   logic [4:0] text_position;
   logic       text_complete;
   logic       last;

   modport source (output valid, out_kind, out_byte, text_position, text_complete, last,
                   input ready);
   modport sink (input valid, out_kind, out_byte, text_position, text_complete, last,
                 output ready);
endinterface

`default_nettype wire

/* design/sdfd_ctrl.sv */
`default_nettype none

module sdfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sdfd_pkg::sdfd_stat_type stat,
   output sdfd_pkg::sdfd_ctl_type  ctl
);
   import sdfd_pkg::*;

   sdfd_state_type state_ff;
   sdfd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.job_some) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free && stat.job_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctl.load  = 1'b0;
      ctl.emit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         ST_EMIT: begin
            ctl.emit = stat.out_free;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

/* design/sdfd_datapath.sv */
`default_nettype none

module sdfd_datapath #(
   parameter int TEXT_LEN = sdfd_pkg::TEXT_LEN_DEF,
   parameter int FAST_MAX = sdfd_pkg::FAST_MAX_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sdfd_pkg::sdfd_ctl_type  ctl,
   output sdfd_pkg::sdfd_stat_type stat,
   input  logic [1:0]              req_command,
   input  logic [31:0]             req_voice_first,
   input  logic [31:0]             req_voice_second,
   input  logic [23:0]             req_slow_data,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_out_kind,
   output logic [7:0]              rsp_out_byte,
   output logic [4:0]              rsp_text_position,
   output logic                    rsp_text_complete,
   output logic                    rsp_last
);
   import sdfd_pkg::*;

   localparam int BUF_BYTES = (FAST_MAX < 3) ? 3 : FAST_MAX;
   localparam int BUF_W     = 8 * BUF_BYTES;
   localparam int CW        = $clog2(BUF_BYTES + 1);
   localparam int TW        = $clog2(TEXT_LEN + 1);
   localparam logic [TW-1:0] TEXT_LIM = TW'(TEXT_LEN);
   localparam logic [4:0]    FAST_LIM = 5'(FAST_MAX);

   logic             odd_ff, odd_in;
   logic [3:0]       type_ff, type_in;
   logic [3:0]       rem_ff, rem_in;
   logic [TW-1:0]    text_cnt_ff, text_cnt_in;
   logic [87:0]      even_ff, even_in;
   logic [63:0]      sync_ff, sync_in;
   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [1:0]       job_kind_ff, job_kind_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       out_kind_ff, out_kind_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic [4:0]       out_pos_ff, out_pos_in;
   logic             out_done_ff, out_done_in;
   logic             out_last_ff, out_last_in;

   logic [3:0]       eff_type;
   logic [3:0]       sd_len;
   logic [23:0]      sd_sel;
   logic [1:0]       nchars;
   logic [TW-1:0]    avail;
   logic [CW-1:0]    text_n;
   logic [CW-1:0]    pos_n;
   logic [7:0]       even_ctl;
   logic [4:0]       fast_size;
   logic [CW-1:0]    fast_n;
   logic [223:0]     pkt;
   logic [CW-1:0]    job_n;
   logic [1:0]       job_kind;
   logic [BUF_W-1:0] job_buf;

   assign sd_len   = req_slow_data[3:0];
   assign eff_type = odd_ff ? type_ff : req_slow_data[7:4];
   assign sd_sel   = odd_ff ? req_slow_data : {8'd0, req_slow_data[23:8]};
   assign nchars   = odd_ff ? 2'd3 : 2'd2;
   assign avail    = TEXT_LIM - text_cnt_ff;
   assign text_n   = (avail < TW'(nchars)) ? CW'(avail) : CW'(nchars);

   always_comb begin
      if (odd_ff) begin
         pos_n = (rem_ff < 4'd3) ? CW'(rem_ff) : CW'(3);
      end else begin
         pos_n = (sd_len < 4'd2) ? CW'(sd_len) : CW'(2);
      end
   end

   assign even_ctl  = even_ff[71:64];
   assign fast_size = {1'b0, even_ctl[3:0]} +
                      ((even_ctl[7:4] == TYPE_FAST_LONG) ? LONG_EXTRA : 5'd0);
   assign fast_n    = (fast_size > FAST_LIM) ? CW'(FAST_LIM) : CW'(fast_size);

   // Packet byte 0 sits in the low bits.
   assign pkt = {sync_ff, req_voice_second, req_voice_first, even_ff[63:0],
                 req_slow_data[23:8], even_ff[87:72]};

   always_comb begin
      job_n    = '0;
      job_kind = KIND_POS;
      job_buf  = BUF_W'(sd_sel);
      if (req_command == CMD_DATA) begin
         unique case (eff_type)
            TYPE_TEXT: begin
               job_kind = KIND_TEXT;
               job_n    = text_n;
            end
            TYPE_POS: begin
               job_kind = KIND_POS;
               job_n    = pos_n;
            end
            TYPE_FAST_SHORT, TYPE_FAST_LONG: begin
               if (odd_ff) begin
                  job_kind = KIND_FAST;
                  job_n    = fast_n;
                  job_buf  = BUF_W'(pkt);
               end
            end
            default: ;
         endcase
      end
   end

   assign stat.job_some = (job_n != '0);
   assign stat.job_last = (left_ff == CW'(1));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      odd_in       = odd_ff;
      type_in      = type_ff;
      rem_in       = rem_ff;
      text_cnt_in  = text_cnt_ff;
      even_in      = even_ff;
      sync_in      = sync_ff;
      buf_in       = buf_ff;
      left_in      = left_ff;
      job_kind_in  = job_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_pos_in   = out_pos_ff;
      out_done_in  = out_done_ff;
      out_last_in  = out_last_ff;

      if (ctl.load) begin
         buf_in      = job_buf;
         left_in     = job_n;
         job_kind_in = job_kind;
         unique case (req_command)
            CMD_SYNC: begin
               sync_in = {req_voice_second, req_voice_first};
               odd_in  = 1'b0;
            end
            CMD_CLEAR: begin
               text_cnt_in = '0;
               odd_in      = 1'b0;
            end
            CMD_DATA: begin
               if (!odd_ff) begin
                  type_in = req_slow_data[7:4];
                  if (eff_type == TYPE_POS) begin
                     rem_in = (sd_len > 4'd2) ? sd_len - 4'd2 : 4'd0;
                  end else begin
                     rem_in = sd_len;
                  end
                  if (eff_type == TYPE_FAST_SHORT || eff_type == TYPE_FAST_LONG) begin
                     even_in = {req_slow_data, req_voice_second, req_voice_first};
                  end
               end
               odd_in = !odd_ff;
            end
            default: ;
         endcase
      end

      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         out_kind_in  = job_kind_ff;
         out_byte_in  = buf_ff[7:0];
         out_last_in  = (left_ff == CW'(1));
         out_pos_in   = 5'd0;
         out_done_in  = 1'b0;
         if (job_kind_ff == KIND_TEXT) begin
            out_pos_in  = 5'(text_cnt_ff);
            out_done_in = ((text_cnt_ff + TW'(1)) == TEXT_LIM);
            text_cnt_in = text_cnt_ff + TW'(1);
         end
         buf_in  = buf_ff >> 8;
         left_in = left_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_ff       <= 1'b0;
         type_ff      <= 4'd0;
         rem_ff       <= 4'd0;
         text_cnt_ff  <= '0;
         sync_ff      <= 64'd0;
         left_ff      <= '0;
         job_kind_ff  <= KIND_POS;
         rsp_valid_ff <= 1'b0;
      end else begin
         odd_ff       <= odd_in;
         type_ff      <= type_in;
         rem_ff       <= rem_in;
         text_cnt_ff  <= text_cnt_in;
         sync_ff      <= sync_in;
         left_ff      <= left_in;
         job_kind_ff  <= job_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      even_ff     <= even_in;
      buf_ff      <= buf_in;
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_pos_ff  <= out_pos_in;
      out_done_ff <= out_done_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_kind      = out_kind_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_text_position = out_pos_ff;
   assign rsp_text_complete = out_done_ff;
   assign rsp_last          = out_last_ff;

endmodule

`default_nettype wire

/* design/slow_data_frame_demux.sv */
// Channel    Role    Word
// req_chan   sink    command, voice_first, voice_second, slow_data
// rsp_chan   source  out_kind, out_byte, text_position, text_complete, last
//
// A word is taken while the sequencer is idle, then its results leave one per
// cycle while rsp_chan is not stalled; a word gives N (0 to 28) result words.
// The result register lets the next word be taken while the last result waits.
// Reset is synchronous and clears the frame parity, type, counters and the saved
// sync voice bytes. A stalled rsp_chan holds the current result and the sequencer.
`default_nettype none

module slow_data_frame_demux #(
   parameter int TEXT_LEN = sdfd_pkg::TEXT_LEN_DEF,
   parameter int FAST_MAX = sdfd_pkg::FAST_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sdfd_req_if.sink   req_chan,
   sdfd_rsp_if.source rsp_chan
);
   import sdfd_pkg::*;

   sdfd_ctl_type  ctl;
   sdfd_stat_type stat;

   sdfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   sdfd_datapath #(
      .TEXT_LEN (TEXT_LEN),
      .FAST_MAX (FAST_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .stat              (stat),
      .req_command       (req_chan.command),
      .req_voice_first   (req_chan.voice_first),
      .req_voice_second  (req_chan.voice_second),
      .req_slow_data     (req_chan.slow_data),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_out_kind      (rsp_chan.out_kind),
      .rsp_out_byte      (rsp_chan.out_byte),
      .rsp_text_position (rsp_chan.text_position),
      .rsp_text_complete (rsp_chan.text_complete),
      .rsp_last          (rsp_chan.last)
   );

endmodule

`default_nettype wire

/* design/sdfd_checker.sv */
`default_nettype none

module sdfd_rsp_assert (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [1:0] rsp_out_kind,
   input wire [4:0] rsp_text_position,
   input wire       rsp_text_complete,
   input wire       rsp_last
);
   import sdfd_pkg::*;

   // A result offered but not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // Only message characters carry a text position or a completion flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_TEXT |-> rsp_text_position == 5'd0 &&
      !rsp_text_complete)
      else $error("text fields set on a non-text result");

   // The character that fills the message ends the results of its frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_complete |-> rsp_last)
      else $error("text complete without last");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind slow_data_frame_demux sdfd_rsp_assert u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_out_kind      (rsp_chan.out_kind),
   .rsp_text_position (rsp_chan.text_position),
   .rsp_text_complete (rsp_chan.text_complete),
   .rsp_last          (rsp_chan.last)
);

`default_nettype wire
